[design/shfd_pkg.sv]
`timescale 1ns / 1ps
package shfd_pkg;

	// Header bytes and the shortest legal frame (header, length, one payload, checksum)
	localparam logic [7:0] HDR_FIRST  = 8'hA5;
	localparam logic [7:0] HDR_SECOND = 8'h5A;
	localparam logic [7:0] MIN_FRAME  = 8'd5;

	// Offset of the first payload byte inside a frame
	localparam int unsigned PAYLOAD_OFS = 3;

	// One payload beat handed from the parser to the output stage
	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       last;
	} emit_t;

endpackage

[design/shfd_if.sv]
`timescale 1ns / 1ps
interface shfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface shfd_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_of_frame;

	modport source (output valid, output payload_byte, output last_of_frame, input ready);
	modport sink (input valid, input payload_byte, input last_of_frame, output ready);
endinterface

[design/shfd_ram.sv]
`timescale 1ns / 1ps
module shfd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/shfd_ctrl.sv]
`timescale 1ns / 1ps
module shfd_ctrl #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	output logic                         ram_we,
	output logic [$clog2(MAX_FRAME)-1:0] ram_waddr,
	output logic [7:0]                   ram_wdata,
	output logic [$clog2(MAX_FRAME)-1:0] ram_raddr,
	input  logic [7:0]                   ram_rdata,
	input  logic                         out_free,
	output shfd_pkg::emit_t              emit
);

	localparam int unsigned PTR_W = $clog2(MAX_FRAME);
	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
	localparam int unsigned SUM_W = PTR_W + 1;
	localparam logic [SUM_W-1:0] MAX_S    = SUM_W'(MAX_FRAME);
	localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_FRAME);
	localparam logic [7:0]       MAX_B    = 8'(MAX_FRAME);
	localparam logic [PTR_W-1:0] PAY_OFS  = PTR_W'(shfd_pkg::PAYLOAD_OFS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR0,
		S_CHK0,
		S_CHK1,
		S_CHK2,
		S_SUM,
		S_EMIT
	} state_t;

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic [CNT_W-1:0]   len_q, len_d;
	logic [7:0]         sum_q, sum_d;
	logic [PTR_W-1:0]   off_q, off_d;
	logic               pend_q, pend_d;
	logic [PTR_W-1:0]   rd_off;
	logic [CNT_W-1:0]   fill_inc;
	logic               sum_last;
	logic               pay_last;

	function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
	                                              input logic [SUM_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + n;
		if (s >= MAX_S) begin
			s = s - MAX_S;
		end
		return s[PTR_W-1:0];
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign ram_we    = in_valid && in_ready;
	assign ram_waddr = wrap_add(head_q, SUM_W'(fill_q));
	assign ram_wdata = in_byte;
	assign ram_raddr = wrap_add(head_q, SUM_W'(rd_off));

	assign sum_last = (SUM_W'(off_q) == SUM_W'(len_q - CNT_W'(1)));
	assign pay_last = (SUM_W'(off_q) == SUM_W'(len_q - CNT_W'(2)));
	assign fill_inc = (fill_q == MAX_C) ? fill_q : fill_q + CNT_W'(1);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		fill_d    = fill_q;
		len_d     = len_q;
		sum_d     = sum_q;
		off_d     = off_q;
		pend_d    = pend_q;
		rd_off    = '0;
		emit.vld  = 1'b0;
		emit.data = ram_rdata;
		emit.last = pay_last;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					// a full buffer drops its oldest byte; the new one takes its slot
					if (fill_q == MAX_C) begin
						head_d = wrap_add(head_q, SUM_W'(1));
					end
					fill_d = fill_inc;
					if (pend_q && (fill_inc < len_q)) begin
						state_d = S_IDLE;
					end else begin
						pend_d  = 1'b0;
						state_d = S_HDR0;
					end
				end
			end
			S_HDR0: begin
				rd_off = '0;
				if (fill_q == '0) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_CHK0;
				end
			end
			S_CHK0: begin
				rd_off = PTR_W'(1);
				if (ram_rdata != shfd_pkg::HDR_FIRST) begin
					head_d  = wrap_add(head_q, SUM_W'(1));
					fill_d  = fill_q - CNT_W'(1);
					state_d = S_HDR0;
				end else if (fill_q < CNT_W'(2)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_CHK1;
				end
			end
			S_CHK1: begin
				rd_off = PTR_W'(2);
				if (ram_rdata != shfd_pkg::HDR_SECOND) begin
					head_d  = wrap_add(head_q, SUM_W'(1));
					fill_d  = fill_q - CNT_W'(1);
					state_d = S_HDR0;
				end else if (fill_q < CNT_W'(3)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_CHK2;
				end
			end
			S_CHK2: begin
				rd_off = PAY_OFS;
				if ((ram_rdata < shfd_pkg::MIN_FRAME) || (ram_rdata > MAX_B)) begin
					head_d  = wrap_add(head_q, SUM_W'(1));
					fill_d  = fill_q - CNT_W'(1);
					state_d = S_HDR0;
				end else begin
					len_d = CNT_W'(ram_rdata);
					if (8'(fill_q) < ram_rdata) begin
						// hold the length; later bytes skip the rescan until the frame fills
						pend_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						sum_d   = shfd_pkg::HDR_FIRST + shfd_pkg::HDR_SECOND + ram_rdata;
						off_d   = PAY_OFS;
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				if (sum_last) begin
					rd_off = PAY_OFS;
					if (sum_q == ram_rdata) begin
						off_d   = PAY_OFS;
						state_d = S_EMIT;
					end else begin
						head_d  = wrap_add(head_q, SUM_W'(1));
						fill_d  = fill_q - CNT_W'(1);
						state_d = S_HDR0;
					end
				end else begin
					rd_off = off_q + PTR_W'(1);
					sum_d  = sum_q + ram_rdata;
					off_d  = off_q + PTR_W'(1);
				end
			end
			S_EMIT: begin
				if (!out_free) begin
					// re-read the same byte so the data stays put
					rd_off = off_q;
				end else begin
					emit.vld = 1'b1;
					if (pay_last) begin
						head_d  = wrap_add(head_q, SUM_W'(len_q));
						fill_d  = fill_q - len_q;
						state_d = S_HDR0;
					end else begin
						rd_off = off_q + PTR_W'(1);
						off_d  = off_q + PTR_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			off_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			fill_q  <= fill_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			off_q   <= off_d;
			pend_q  <= pend_d;
		end
	end

endmodule

[design/shfd_out_stage.sv]
`timescale 1ns / 1ps
module shfd_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  shfd_pkg::emit_t emit,
	output logic            out_free,
	shfd_tx_if.source       tx
);

	logic       valid_q;
	logic [7:0] data_q;
	logic       last_q;

	assign out_free         = !valid_q || tx.ready;
	assign tx.valid         = valid_q;
	assign tx.payload_byte  = data_q;
	assign tx.last_of_frame = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.vld) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.vld) begin
			data_q <= emit.data;
			last_q <= emit.last;
		end
	end

endmodule

[design/sync_header_frame_deframer.sv]
`timescale 1ns / 1ps
// Byte-stream deframer: received bytes are appended to a circular buffer of MAX_FRAME bytes
// held in one synchronous RAM (one write and one read port, read data registered). After
// each byte the parser walks the buffer from its head, one RAM read per cycle, looking for
// A5 5A and a length byte L in 5..MAX_FRAME. Once L bytes are buffered it sums the first L-1
// bytes and compares against the last; a match sends the L-4 payload bytes out, the final
// one flagged by last_of_frame, and removes the frame; a mismatch or an illegal length drops
// the head byte and rescans what remains. Each input byte is taken while the parser is idle;
// nothing more follows while a frame with a known length is still filling, otherwise the
// header is checked with one RAM read per header byte. A completed frame is then summed and
// its payload beats sent out, held while the sink stalls. Each dropped byte or removed
// frame is followed by a rescan of the new head, plus another sum when that head holds a
// complete frame. The parser's pace is set by the RAM's single read port.
// The last beat of a frame sits in an output register, so input bytes keep flowing while
// it waits to be taken; earlier beats hold the parser, and with it the input, until the
// register frees up. The buffer needs no clearing pass: only bytes below the fill count
// are ever read.
module sync_header_frame_deframer #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	shfd_rx_if.sink   rx,
	shfd_tx_if.source tx
);

	localparam int unsigned PTR_W = $clog2(MAX_FRAME);

	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	logic [7:0]       ram_wdata;
	logic [PTR_W-1:0] ram_raddr;
	logic [7:0]       ram_rdata;
	logic             out_free;
	shfd_pkg::emit_t  emit;

	// frame buffer
	shfd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_FRAME)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// hunt, length check, checksum and payload replay
	shfd_ctrl #(
		.MAX_FRAME (MAX_FRAME)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.emit      (emit)
	);

	// hold each payload beat until the sink takes it
	shfd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.out_free (out_free),
		.tx       (tx)
	);

	// never overwrite a beat the sink has not taken
	assert property (@(posedge clk) disable iff (!arst_n) emit.vld |-> out_free)
		else $error("payload beat issued while output register is occupied");

	// the parser emits only while no input byte is being taken
	assert property (@(posedge clk) disable iff (!arst_n) (rx.valid && rx.ready) |-> !emit.vld)
		else $error("payload emitted in the cycle of an input beat");

	// an output beat appears only after the parser handed one over
	assert property (@(posedge clk) disable iff (!arst_n) $rose(tx.valid) |-> $past(emit.vld))
		else $error("output valid rose without a payload beat");

endmodule

[verif/shfd_payload_monitor.sv]
`timescale 1ns / 1ps
module shfd_payload_monitor #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic clk,
	input  logic arst_n,
	shfd_rx_if   rx,
	shfd_tx_if   tx,
	output int   mismatches,
	output int   outstanding
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} payload_beat_t;

	logic [7:0]    rx_window[$];
	payload_beat_t payload_due[$];

	// Append one byte, then resolve every frame the window now allows
	function automatic void deframe_byte(input logic [7:0] b);
		logic [7:0] len;
		logic [7:0] sum;
		bit         scanning;
		int         i;
		scanning = 1'b1;
		if (rx_window.size() >= MAX_FRAME)
			void'(rx_window.pop_front());
		rx_window.push_back(b);
		while (scanning) begin
			if (rx_window.size() == 0) begin
				scanning = 1'b0;
			end else if (rx_window[0] != shfd_pkg::HDR_FIRST) begin
				void'(rx_window.pop_front());
			end else if (rx_window.size() < 2) begin
				scanning = 1'b0;
			end else if (rx_window[1] != shfd_pkg::HDR_SECOND) begin
				void'(rx_window.pop_front());
			end else if (rx_window.size() < 3) begin
				scanning = 1'b0;
			end else begin
				len = rx_window[2];
				if (len < shfd_pkg::MIN_FRAME || len > MAX_FRAME) begin
					void'(rx_window.pop_front());
				end else if (rx_window.size() < len) begin
					scanning = 1'b0;
				end else begin
					sum = 8'h00;
					for (i = 0; i < len - 1; i++)
						sum = sum + rx_window[i];
					if (sum == rx_window[len - 1]) begin
						for (i = shfd_pkg::PAYLOAD_OFS; i < len - 1; i++)
							payload_due.push_back('{data: rx_window[i], last: (i == len - 2)});
						repeat (len) void'(rx_window.pop_front());
					end else begin
						void'(rx_window.pop_front());
					end
				end
			end
		end
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		payload_beat_t want;
		if (arst_n) begin
			if (rx.valid && rx.ready)
				deframe_byte(rx.rx_byte);
			if (tx.valid && tx.ready) begin
				if (payload_due.size() == 0) begin
					$error("unexpected beat: payload_byte=%h last_of_frame=%b",
						tx.payload_byte, tx.last_of_frame);
					mismatches++;
				end else begin
					want = payload_due.pop_front();
					if (tx.payload_byte !== want.data) begin
						$error("payload_byte: expected %h, got %h", want.data, tx.payload_byte);
						mismatches++;
					end
					if (tx.last_of_frame !== want.last) begin
						$error("last_of_frame: expected %b, got %b", want.last, tx.last_of_frame);
						mismatches++;
					end
				end
			end
			outstanding = payload_due.size();
		end
	end

endmodule

[verif/sync_header_frame_deframer_tb.sv]
`timescale 1ns / 1ps
module sync_header_frame_deframer_tb;

	localparam int unsigned MAX_FRAME   = 64;
	// Cycles with no beat on either channel before the run is declared hung.
	// A long bad frame full of embedded headers is rescanned from each of its bytes in turn.
	localparam int          STALL_LIMIT = 20000;
	localparam int          HOLD_CYCLES = 400;  // long sink hold-off to back up the input
	localparam int          TAIL_CYCLES = 300;  // let trailing rescans settle at the end

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	shfd_rx_if rx_ch ();
	shfd_tx_if tx_ch ();

	int mismatches;
	int outstanding;
	int stall_cycles;
	int bytes_sent;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_reqs;
	int holds_done;

	sync_header_frame_deframer #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	shfd_payload_monitor #(.MAX_FRAME(MAX_FRAME)) mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_ch),
		.tx          (tx_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hang detection: count cycles where neither channel moves a beat
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Sink side: random back-pressure, or a long hold-off when one is requested.
	// At most one assignment to ready per falling edge.
	initial begin
		tx_ch.ready = 1'b0;
		holds_done  = 0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_reqs) begin
				tx_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else begin
				tx_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Offer one byte, inserting random idle cycles first; hold valid across
	// back-to-back beats so it is never dropped and raised in the same step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_bytes(input byte_q_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	// Payload content: mostly random, with header bytes mixed in so that
	// rescans after a bad frame find false starts inside the payload
	function automatic byte_q_t rand_body(input int n);
		byte_q_t body;
		int      r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8)
				body.push_back(shfd_pkg::HDR_FIRST);
			else if (r < 16)
				body.push_back(shfd_pkg::HDR_SECOND);
			else
				body.push_back(8'($urandom_range(255)));
		end
		return body;
	endfunction

	// Wrap a payload into header, length, payload and checksum; corrupt the
	// checksum by a nonzero offset when asked
	function automatic byte_q_t build_frame(input int len, input byte_q_t body, input bit corrupt);
		byte_q_t    frame;
		logic [7:0] sum;
		sum = 8'h00;
		frame.push_back(shfd_pkg::HDR_FIRST);
		frame.push_back(shfd_pkg::HDR_SECOND);
		frame.push_back(8'(len));
		foreach (body[i])
			frame.push_back(body[i]);
		foreach (frame[i])
			sum = sum + frame[i];
		if (corrupt)
			sum = sum + 8'($urandom_range(1, 255));
		frame.push_back(sum);
		return frame;
	endfunction

	// Mostly short frames, a few up to and at the buffer size
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return MAX_FRAME;
		else if (r < 15)
			return $urandom_range(13, MAX_FRAME - 1);
		else
			return $urandom_range(shfd_pkg::MIN_FRAME, 12);
	endfunction

	// Random traffic: mostly well-formed frames, the rest broken sequences and noise
	task automatic random_traffic(input int nbytes);
		byte_q_t frame;
		byte_q_t inner;
		int      target;
		int      len;
		int      r;
		target = bytes_sent + nbytes;
		while (bytes_sent < target) begin
			r   = $urandom_range(99);
			len = pick_len();
			if (r < 60) begin
				frame = build_frame(len, rand_body(len - 4), 1'b0);
			end else if (r < 70) begin
				frame = build_frame(len, rand_body(len - 4), 1'b1);
			end else if (r < 78) begin
				// good frame hidden in the payload of a bad one: surfaces on the rescan
				inner = build_frame($urandom_range(shfd_pkg::MIN_FRAME, 20), rand_body(0), 1'b0);
				inner = build_frame(inner[2], rand_body(inner[2] - 4), 1'b0);
				frame = build_frame(inner.size() + 4, inner, 1'b1);
			end else if (r < 86) begin
				// cut a good frame short; the next frame lands in its body
				frame = build_frame(len, rand_body(len - 4), 1'b0);
				frame = frame[0:$urandom_range(frame.size() - 2)];
			end else if (r < 93) begin
				frame = rand_body($urandom_range(1, 4));
			end else begin
				frame.delete();
				frame.push_back(shfd_pkg::HDR_FIRST);
				frame.push_back(shfd_pkg::HDR_SECOND);
				if ($urandom_range(1))
					frame.push_back(8'($urandom_range(shfd_pkg::MIN_FRAME - 1)));
				else
					frame.push_back(8'($urandom_range(MAX_FRAME + 1, 255)));
			end
			send_bytes(frame);
		end
	endtask

	// Drop valid and wait for every predicted beat to come out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		byte_q_t pattern;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = 8'h00;
		arst_n         = 1'b0;
		bytes_sent     = 0;
		hold_reqs      = 0;
		src_idle_pct   = 31;
		sink_stall_pct = 72;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Stray bytes at both extremes: dropped while hunting
		pattern = '{8'h00, 8'hFF};
		send_bytes(pattern);
		// Shortest legal frame, payload all zeros
		pattern = '{8'h00};
		send_bytes(build_frame(shfd_pkg::MIN_FRAME, pattern, 1'b0));
		// Length one below the minimum, then one above the buffer size
		pattern = '{shfd_pkg::HDR_FIRST, shfd_pkg::HDR_SECOND, shfd_pkg::MIN_FRAME - 8'd1};
		send_bytes(pattern);
		pattern = '{shfd_pkg::HDR_FIRST, shfd_pkg::HDR_SECOND, 8'(MAX_FRAME + 1)};
		send_bytes(pattern);
		// Bad checksum, then a good frame right behind it
		pattern = '{8'hFF};
		send_bytes(build_frame(shfd_pkg::MIN_FRAME, pattern, 1'b1));
		pattern = '{8'hFF, 8'h00};
		send_bytes(build_frame(shfd_pkg::MIN_FRAME + 1, pattern, 1'b0));

		// Largest frame the buffer holds, then random traffic with a slow sink
		send_bytes(build_frame(MAX_FRAME, rand_body(MAX_FRAME - 4), 1'b0));
		random_traffic(55);

		// Swap the idle rates: slow source, mostly ready sink
		src_idle_pct   = 72;
		sink_stall_pct = 31;
		random_traffic(55);

		// Pause the source until everything has come out
		drain();

		// Full rate; start with a long sink hold-off so the input backs up
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_reqs++;
		random_traffic(55);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
